### design/crc8_checked_frame_parser_top_assert.svh
// Assertion macros shared by the frame parser.
`ifndef CRC8_CHECKED_FRAME_PARSER_TOP_ASSERT_SVH
`define CRC8_CHECKED_FRAME_PARSER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame parser assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame parser assertion failed");

`endif

### design/crc8cfp_pkg.sv
`default_nettype none

package crc8cfp_pkg;

    localparam int BUFFER_DEPTH_DEF = 32;
    localparam int BYTE_W           = 8;
    localparam int LEN_W            = 5;
    localparam int POS_W            = 5;
    localparam int CFG_DATA_W       = 8;
    localparam int CFG_INDEX_W      = 1;
    localparam int IN_TDATA_W       = 8;
    localparam int OUT_TDATA_W      = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_PREAMBLE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH   = 1'd1;

    localparam logic [BYTE_W-1:0] PREAMBLE_RESET = 8'h00;
    localparam logic [LEN_W-1:0]  LENGTH_RESET   = 5'd3;
    localparam logic [LEN_W-1:0]  LENGTH_MIN     = 5'd3;

    // Contribution of each set bit of the table index to the reflected
    // Dallas/Maxim CRC-8 table entry.
    localparam logic [BYTE_W-1:0] CRC_BIT_TABLE [8] = '{
        8'h5E, 8'hBC, 8'h61, 8'hC2, 8'h9D, 8'h23, 8'h46, 8'h8C
    };

    function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] k);
        logic [BYTE_W-1:0] c;
        c = '0;
        for (int b = 0; b < 8; b++) begin
            if (k[b]) begin
                c = c ^ CRC_BIT_TABLE[b];
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### design/crc8_checked_frame_parser_top.sv
// Data and preamble bytes: one transfer per cycle while no CRC walk or emission runs.
// Check byte of a frame: the CRC walk reads each stored byte before the check
// byte (ST_CRC_RD, then ST_CRC_UP) through the frame store's registered read
// port; if the check matches, emission reads and offers each byte in turn
// (ST_EM_RD, then ST_EM_OUT) and holds in ST_EM_OUT under back-pressure.
// Synchronous active-low reset returns to preamble hunting; the store is not cleared.
`default_nettype none

module crc8_checked_frame_parser_top #(
    parameter int BUFFER_DEPTH = crc8cfp_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // Configuration write port.
    input  wire logic                                 i_cfg_we,
    input  wire logic [crc8cfp_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [crc8cfp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Input stream. tdata fields from bit 0: rx_byte[7:0].
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    input  wire logic [crc8cfp_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // Output stream. tdata fields from bit 0: frame_byte[7:0],
    // byte_position[12:8], zero padding[15:13]. tlast carries last_byte.
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    output logic [crc8cfp_pkg::OUT_TDATA_W-1:0]       o_m_tdata,
    output logic                                      o_m_tlast
);

    import crc8cfp_pkg::*;

    // The counter must be able to hold BUFFER_DEPTH itself.
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int XW = (CW > LEN_W) ? CW : LEN_W;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_DATA,
        PH_CHECK
    } t_phase;

    // Sequencer of the shared CRC step and the emission path.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CRC_RD,
        ST_CRC_UP,
        ST_EM_RD,
        ST_EM_OUT
    } t_state;

    t_phase             r_phase;
    t_state             r_state;
    logic [BYTE_W-1:0]  r_preamble;
    logic [LEN_W-1:0]   r_length;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    logic [BYTE_W-1:0]  r_crc;
    logic [BYTE_W-1:0]  r_check;
    logic [BYTE_W-1:0]  r_rd_data;
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    logic [POS_W-1:0]   r_out_pos;
    logic               r_out_last;

    logic [BYTE_W-1:0]  r_mem [BUFFER_DEPTH];

    logic               w_accept;
    logic [BYTE_W-1:0]  w_byte;
    logic [LEN_W-1:0]   w_eff_m1;
    logic [CW-1:0]      w_count_inc;
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    logic [BYTE_W-1:0]  w_k;
    logic [CW+POS_W-1:0] w_idx_ext;
    logic               w_in_walk;
    logic               w_in_emit;
    logic               w_check_xfer;
    logic               w_count_ok;
    logic               w_walk_begun;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_byte     = i_s_tdata[BYTE_W-1:0];
    assign w_count_inc = r_count + CW'(1);

    // A configured length below three counts as three.
    assign w_eff_m1 = ((r_length < LENGTH_MIN) ? LENGTH_MIN : r_length) - LEN_W'(1);

    // Table index of the current CRC step, formed from the registered read data.
    assign w_k = r_rd_data ^ r_crc;

    assign w_idx_ext = {{POS_W{1'b0}}, r_idx};

    // Frame store writes: preamble, data bytes and the check byte.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_count[AW-1:0];
        if (w_accept) begin
            case (r_phase)
                PH_DATA: begin
                    w_wr_en = (r_count < CW'(BUFFER_DEPTH - 1));
                end
                PH_CHECK: begin
                    w_wr_en = (r_count < CW'(BUFFER_DEPTH));
                end
                default: begin
                    w_wr_en   = (w_byte == r_preamble);
                    w_wr_addr = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_byte;
        end
        r_rd_data <= r_mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_state     <= ST_IDLE;
            r_preamble  <= PREAMBLE_RESET;
            r_length    <= LENGTH_RESET;
            r_count     <= '0;
            r_idx       <= '0;
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PREAMBLE: r_preamble <= i_cfg_data[BYTE_W-1:0];
                    REG_LENGTH:   r_length   <= i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end

            // The output register empties on a transfer; while emitting it is
            // reloaded below in the same cycle instead.
            if (i_m_tready && (r_state != ST_EM_OUT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        case (r_phase)
                            PH_DATA: begin
                                if (r_count >= CW'(BUFFER_DEPTH - 1)) begin
                                    // Buffer overflow guard: drop the frame.
                                    r_phase <= PH_HUNT;
                                end else begin
                                    r_count <= w_count_inc;
                                    if (XW'(w_count_inc) >= XW'(w_eff_m1)) begin
                                        r_phase <= PH_CHECK;
                                    end
                                end
                            end
                            PH_CHECK: begin
                                r_phase <= PH_HUNT;
                                if (r_count < CW'(BUFFER_DEPTH)) begin
                                    r_count <= w_count_inc;
                                    r_check <= w_byte;
                                    r_idx   <= '0;
                                    r_crc   <= '0;
                                    r_state <= ST_CRC_RD;
                                end
                            end
                            default: begin
                                if (w_byte == r_preamble) begin
                                    r_count <= CW'(1);
                                    r_phase <= PH_DATA;
                                end else begin
                                    r_count <= '0;
                                    r_phase <= PH_HUNT;
                                end
                            end
                        endcase
                    end
                end
                ST_CRC_RD: begin
                    r_state <= ST_CRC_UP;
                end
                ST_CRC_UP: begin
                    r_crc <= crc8_step(w_k);
                    if (r_idx == r_count - CW'(2)) begin
                        // The final table index must match the check byte.
                        r_idx   <= '0;
                        r_state <= (w_k == r_check) ? ST_EM_RD : ST_IDLE;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= ST_CRC_RD;
                    end
                end
                ST_EM_RD: begin
                    r_state <= ST_EM_OUT;
                end
                ST_EM_OUT: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= r_rd_data;
                        r_out_pos   <= w_idx_ext[POS_W-1:0];
                        r_out_last  <= (r_idx == r_count - CW'(1));
                        if (r_idx == r_count - CW'(1)) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx   <= r_idx + CW'(1);
                            r_state <= ST_EM_RD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_TDATA_W - BYTE_W - POS_W)'(0), r_out_pos, r_out_byte};
    assign o_m_tlast  = r_out_last;

    // Terms used by the checks below.
    assign w_in_walk    = (r_state == ST_CRC_RD) || (r_state == ST_CRC_UP);
    assign w_in_emit    = (r_state == ST_EM_RD) || (r_state == ST_EM_OUT);
    assign w_check_xfer = w_accept && (r_phase == PH_CHECK);
    assign w_count_ok   = (r_count != '0) && (r_count < CW'(BUFFER_DEPTH));
    assign w_walk_begun = (r_state == ST_CRC_RD) && (r_idx == '0) && (r_phase == PH_HUNT);

`include "crc8_checked_frame_parser_top_assert.svh"

    // While collecting, the frame holds at least the preamble and has room left.
    `CFP_ASSERT_SAME(a_data_count, i_clk, i_rst_n, r_phase == PH_DATA, w_count_ok)
    // The CRC walk never runs past the byte before the check byte.
    `CFP_ASSERT_SAME(a_crc_idx, i_clk, i_rst_n, w_in_walk, (r_idx + CW'(2)) <= r_count)
    // Emission only addresses bytes stored for the current frame.
    `CFP_ASSERT_SAME(a_emit_idx, i_clk, i_rst_n, w_in_emit, r_idx < r_count)
    // A check byte transfer starts the walk from the first stored byte.
    `CFP_ASSERT_NEXT(a_check_start, i_clk, i_rst_n, w_check_xfer, w_walk_begun)

endmodule

`default_nettype wire

### tb/crc8_checked_frame_parser_checker.sv
module crc8_checked_frame_parser_checker #(
    parameter int DEPTH = crc8cfp_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [crc8cfp_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [crc8cfp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                                 i_s_tvalid,
    input  wire logic                                 i_s_tready,
    // rx_byte[7:0]
    input  wire logic [crc8cfp_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  wire logic                                 i_m_tvalid,
    input  wire logic                                 i_m_tready,
    // frame_byte[7:0], byte_position[12:8], zero padding[15:13]
    input  wire logic [crc8cfp_pkg::OUT_TDATA_W-1:0]  i_m_tdata,
    input  wire logic                                 i_m_tlast,
    output int                                        o_pending,
    output int                                        o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        PH_HUNT        = 2'd0,
        PH_COLLECT     = 2'd1,
        PH_AWAIT_CHECK = 2'd2,
        PH_SPARE       = 2'd3
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic [4:0] pos;
        logic       last;
    } frame_beat_t;

    // Reflected Dallas/Maxim CRC-8: table entry for each single set index bit.
    localparam logic [7:0] CRC_BIT_TERMS [8] = '{
        8'h5E, 8'hBC, 8'h61, 8'hC2, 8'h9D, 8'h23, 8'h46, 8'h8C
    };

    logic [7:0]   preamble_byte;
    logic [4:0]   frame_len;
    parse_phase_t phase;
    int           stored;
    logic [7:0]   frame_mem [DEPTH];
    frame_beat_t  accepted_beats [$];

    function automatic logic [7:0] crc_table_entry(input logic [7:0] k);
        logic [7:0] c;
        c = 8'h00;
        for (int b = 0; b < 8; b++) begin
            if (k[b]) begin
                c = c ^ CRC_BIT_TERMS[b];
            end
        end
        return c;
    endfunction

    // Advance the parser model by one received byte and queue any frame it completes with a matching check byte.
    function automatic void absorb_byte(input logic [7:0] b);
        logic [7:0]  crc;
        logic [7:0]  k;
        int          eff_len;
        frame_beat_t beat;
        crc     = 8'h00;
        k       = 8'h00;
        eff_len = (frame_len < 5'd3) ? 3 : int'(frame_len);
        case (phase)
            PH_COLLECT: begin
                if (stored >= DEPTH - 1) begin
                    phase = PH_HUNT;
                end else begin
                    frame_mem[stored] = b;
                    stored++;
                    if (stored >= eff_len - 1) begin
                        phase = PH_AWAIT_CHECK;
                    end
                end
            end
            PH_AWAIT_CHECK: begin
                phase = PH_HUNT;
                if (stored < DEPTH) begin
                    frame_mem[stored] = b;
                    stored++;
                    for (int i = 0; i + 1 < stored; i++) begin
                        k   = frame_mem[i] ^ crc;
                        crc = crc_table_entry(k);
                    end
                    if (b == k) begin
                        for (int i = 0; i < stored; i++) begin
                            beat.data = frame_mem[i];
                            beat.pos  = 5'(i);
                            beat.last = (i + 1 == stored);
                            accepted_beats.push_back(beat);
                        end
                    end
                end
            end
            default: begin
                stored = 0;
                phase  = PH_HUNT;
                if (b == preamble_byte) begin
                    frame_mem[0] = b;
                    stored       = 1;
                    phase        = PH_COLLECT;
                end
            end
        endcase
    endfunction

    function automatic void check_beat();
        frame_beat_t want;
        if (accepted_beats.size() == 0) begin
            o_fail_count++;
            $display("%0t: unexpected output transfer, expected none, actual tdata %04h last %0b",
                     $time, i_m_tdata, i_m_tlast);
            return;
        end
        want = accepted_beats.pop_front();
        if (i_m_tdata[7:0] !== want.data) begin
            o_fail_count++;
            $display("%0t: frame byte mismatch, expected %02h, actual %02h",
                     $time, want.data, i_m_tdata[7:0]);
        end
        if (i_m_tdata[12:8] !== want.pos) begin
            o_fail_count++;
            $display("%0t: byte position mismatch, expected %0d, actual %0d",
                     $time, want.pos, i_m_tdata[12:8]);
        end
        if (i_m_tlast !== want.last) begin
            o_fail_count++;
            $display("%0t: last marker mismatch, expected %0b, actual %0b",
                     $time, want.last, i_m_tlast);
        end
        if (i_m_tdata[15:13] !== 3'b000) begin
            o_fail_count++;
            $display("%0t: tdata padding mismatch, expected 0, actual %0h",
                     $time, i_m_tdata[15:13]);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            preamble_byte = crc8cfp_pkg::PREAMBLE_RESET;
            frame_len     = crc8cfp_pkg::LENGTH_RESET;
            phase         = PH_HUNT;
            stored        = 0;
            accepted_beats.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    crc8cfp_pkg::REG_PREAMBLE: preamble_byte = i_cfg_data[7:0];
                    crc8cfp_pkg::REG_LENGTH:   frame_len     = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                check_beat();
            end
            if (i_s_tvalid && i_s_tready) begin
                absorb_byte(i_s_tdata[7:0]);
            end
        end
        o_pending = accepted_beats.size();
    end

endmodule

### tb/crc8_checked_frame_parser_top_test.sv
module crc8_checked_frame_parser_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import crc8cfp_pkg::*;

    // Kinds of frame the stimulus can build.
    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_CHECK,
        FRAME_BAD_BODY,
        FRAME_CUT
    } frame_kind_t;

    // Quiet time after the last result; it covers a rejected frame that is still
    // being walked when the last result has arrived.
    localparam int QUIET_CYCLES  = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASE_ITEMS   = 48;
    localparam int PHASE_COUNT   = 9;
    // Frame length for the first phases: the short-length cases, the largest
    // length and a few ordinary ones. Later phases pick at random.
    localparam logic [4:0] PHASE_LENGTHS [7] = '{
        5'd1, 5'd31, 5'd3, 5'd4, 5'd6, 5'd31, 5'd0
    };

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    // rx_byte[7:0]
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    // frame_byte[7:0], byte_position[12:8], zero padding[15:13]
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;

    int pending;
    int fail_count;
    int cycle_count = 0;

    // The receiver serves one long hold-off each time the stimulus asks for one.
    int hold_asked = 0;
    int hold_done  = 0;

    // Stimulus-side copy of the settings, used only to build frames.
    logic [7:0] cur_preamble = PREAMBLE_RESET;
    logic [4:0] cur_len      = LENGTH_RESET;
    logic [7:0] frame_buf [32];
    int         bytes_sent = 0;
    int         burst_left = 0;

    always #5 i_clk = ~i_clk;

    crc8_checked_frame_parser_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    crc8_checked_frame_parser_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: segments of random length, each with its own stall pattern,
    // from always ready to mostly stalled. When asked, it holds off for a long
    // stretch so that the block fills up and has to stall its input.
    initial begin
        int seg;
        int mode;
        @(posedge i_clk);
        forever begin
            if (hold_done != hold_asked) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done++;
            end else begin
                seg  = $urandom_range(1, 40);
                mode = $urandom_range(0, 3);
                repeat (seg) begin
                    case (mode)
                        0:       i_m_tready <= 1'b1;
                        1:       i_m_tready <= 1'($urandom_range(0, 1));
                        2:       i_m_tready <= ($urandom_range(0, 3) == 0);
                        default: i_m_tready <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Bitwise form of the reflected CRC-8 (polynomial 0x8C). The check byte is
    // the second-to-last byte XOR the CRC of everything before it.
    function automatic logic [7:0] seal_byte(input int n);
        logic [7:0] crc;
        crc = 8'h00;
        for (int i = 0; i < n - 2; i++) begin
            crc = crc ^ frame_buf[i];
            for (int b = 0; b < 8; b++) begin
                crc = crc[0] ? ((crc >> 1) ^ 8'h8C) : (crc >> 1);
            end
        end
        return frame_buf[n - 2] ^ crc;
    endfunction

    // Offers one byte and returns at the edge where the transfer happens.
    // The sender runs in bursts of random length separated by random gaps;
    // roughly a quarter of the bursts follow the previous one with no gap.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        // tready only changes at a rising edge, so its value mid-cycle tells
        // whether the coming edge completes the transfer.
        do @(negedge i_clk); while (!o_s_tready);
        @(posedge i_clk);
        bytes_sent++;
    endtask

    // Stops offering and waits until every expected result has come, then
    // lets the block finish any check walk of a frame that will be dropped.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Registers are only written while nothing is in flight.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == REG_PREAMBLE) begin
            cur_preamble = val;
        end else begin
            cur_len = val[4:0];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_sealed(input int n);
        frame_buf[n - 1] = seal_byte(n);
        for (int i = 0; i < n; i++) begin
            send_byte(frame_buf[i]);
        end
    endtask

    // Builds a frame at the current settings with random body bytes, then
    // spoils it as the kind asks: a flipped bit in the check byte or in the
    // body (a single-bit error is always caught), or a frame cut short.
    task automatic send_frame(input frame_kind_t kind);
        int         n;
        int         upto;
        logic [7:0] flip;
        n            = (cur_len < 5'd3) ? 3 : int'(cur_len);
        upto         = n;
        flip         = 8'h01 << $urandom_range(0, 7);
        frame_buf[0] = cur_preamble;
        for (int i = 1; i < n - 1; i++) begin
            frame_buf[i] = 8'($urandom);
        end
        frame_buf[n - 1] = seal_byte(n);
        case (kind)
            FRAME_BAD_CHECK: frame_buf[n - 1] = frame_buf[n - 1] ^ flip;
            FRAME_BAD_BODY: begin
                upto = $urandom_range(1, n - 2);
                frame_buf[upto] = frame_buf[upto] ^ flip;
                upto = n;
            end
            FRAME_CUT:       upto = $urandom_range(1, n - 1);
            default: ;
        endcase
        for (int i = 0; i < upto; i++) begin
            send_byte(frame_buf[i]);
        end
    endtask

    initial begin
        int          phase_end;
        int          r;
        logic [4:0]  len;
        logic [7:0]  pre;

        // Synchronous reset, held at the start only.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset settings: preamble 0x00, three-byte
        // frames. Good frames with all-ones and all-zeros bodies, then a
        // frame with a wrong check byte, then a stray byte while hunting.
        frame_buf[0] = 8'h00;
        frame_buf[1] = 8'hFF;
        send_sealed(3);
        frame_buf[1] = 8'h00;
        send_sealed(3);
        send_byte(8'h00);
        send_byte(8'h5A);
        send_byte(8'h5B);
        send_byte(8'h7E);

        // Lengths below three behave as three.
        write_reg(REG_PREAMBLE, 8'hFF);
        write_reg(REG_LENGTH, 8'd0);
        frame_buf[0] = 8'hFF;
        frame_buf[1] = 8'h80;
        send_sealed(3);
        write_reg(REG_LENGTH, 8'd2);
        frame_buf[1] = 8'($urandom);
        send_sealed(3);

        // Length changed in the middle of a frame: start a long frame, cut the
        // length to four; it closes after one more body byte and its check byte.
        write_reg(REG_LENGTH, 8'd31);
        for (int i = 1; i < 5; i++) begin
            frame_buf[i] = 8'($urandom);
        end
        for (int i = 0; i < 5; i++) begin
            send_byte(frame_buf[i]);
        end
        write_reg(REG_LENGTH, 8'd4);
        frame_buf[5] = 8'($urandom);
        frame_buf[6] = seal_byte(7);
        send_byte(frame_buf[5]);
        send_byte(frame_buf[6]);

        // Random part: mostly well-formed frames with random bodies, the
        // rest spoilt frames, cut frames and loose bytes. Each phase runs at
        // new settings; a phase may end with a frame left half-done so that
        // the next settings take effect mid-frame.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            pre = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom);
            len = (p < 7) ? PHASE_LENGTHS[p] : 5'($urandom_range(3, 20));
            write_reg(REG_PREAMBLE, pre);
            write_reg(REG_LENGTH, {3'b000, len});
            if (p == 3) begin
                // Short frames arriving while the receiver holds off.
                hold_asked++;
            end
            phase_end = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < phase_end) begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    send_frame(FRAME_GOOD);
                end else if (r < 75) begin
                    send_frame(FRAME_BAD_CHECK);
                end else if (r < 82) begin
                    send_frame(FRAME_BAD_BODY);
                end else if (r < 90) begin
                    send_frame(FRAME_CUT);
                end else begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
                end
                if ($urandom_range(0, 39) == 0) begin
                    settle();
                end
            end
            if ($urandom_range(0, 1) == 1) begin
                send_frame(FRAME_CUT);
            end
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
